// File: src/bced_pkg.sv
package bced_pkg;

  // Field widths
  localparam int unsigned DebW   = 10;
  localparam int unsigned WinW   = 12;
  localparam int unsigned DurW   = 20;
  localparam int unsigned CfgW   = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 48;

  // Saturation limits of the timers
  localparam logic [WinW-1:0] WinMax = '1;
  localparam logic [DurW-1:0] DurMax = '1;

  // Register reset values
  localparam logic            RstEventsEnable = 1'b0;
  localparam logic [DebW-1:0] RstDebounce     = 10'd50;
  localparam logic [WinW-1:0] RstWindow       = 12'd300;
  localparam logic [DurW-1:0] RstHoldLimit    = 20'd60000;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegEventsEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDebounce     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWindow       = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHoldLimit    = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DEB1,
    PH_HELD,
    PH_WIN,
    PH_DEB2,
    PH_HELD2
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DOWN   = 2'd1,
    EV_UP     = 2'd2,
    EV_DOUBLE = 2'd3
  } event_e;

  typedef struct packed {
    logic            events_enable;
    logic [DebW-1:0] debounce_ms;
    logic [WinW-1:0] window_ms;
    logic [DurW-1:0] hold_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic            pressed;
    logic [DurW-1:0] held_ms;
    logic [DurW-1:0] press_len_ms;
    event_e          event_res;
  } result_t;

endpackage

// File: src/bced_fsm.sv
module bced_fsm import bced_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    level_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  phase_e          phase_q, phase_d;
  logic [WinW-1:0] phase_tmr_q, phase_tmr_d;
  logic [DurW-1:0] press_tmr_q, press_tmr_d;
  logic [WinW-1:0] win_tmr_q, win_tmr_d;
  logic            prev_level_q;

  logic [WinW-1:0] phase_tmr_inc;
  logic [DurW-1:0] press_tmr_inc;
  logic [WinW-1:0] win_tmr_inc;
  logic            deb_done;
  logic            release_now;
  event_e          ev;
  logic [DurW-1:0] dur;
  logic [DurW-1:0] held;

  // Saturating increments and the shared compares
  assign phase_tmr_inc = (phase_tmr_q == WinMax) ? phase_tmr_q : phase_tmr_q + 1'b1;
  assign press_tmr_inc = (press_tmr_q == DurMax) ? press_tmr_q : press_tmr_q + 1'b1;
  assign win_tmr_inc   = (win_tmr_q == WinMax) ? win_tmr_q : win_tmr_q + 1'b1;
  assign deb_done      = phase_tmr_inc >= {{(WinW-DebW){1'b0}}, cfg_i.debounce_ms};
  assign release_now   = level_i || (press_tmr_inc > cfg_i.hold_limit_ms) ||
                         (press_tmr_inc == DurMax);

  // Next state and timers
  always_comb begin
    phase_d     = phase_q;
    phase_tmr_d = phase_tmr_q;
    press_tmr_d = press_tmr_q;
    win_tmr_d   = win_tmr_q;
    case (phase_q)
      PH_IDLE: begin
        if (prev_level_q && !level_i) begin
          phase_d     = PH_DEB1;
          phase_tmr_d = '0;
        end
      end
      PH_DEB1: begin
        phase_tmr_d = phase_tmr_inc;
        if (deb_done) begin
          if (!level_i) begin
            press_tmr_d = '0;
            phase_d     = PH_HELD;
          end else begin
            phase_d = PH_IDLE;
          end
        end
      end
      PH_HELD: begin
        press_tmr_d = press_tmr_inc;
        if (release_now) begin
          press_tmr_d = '0;
          win_tmr_d   = '0;
          phase_d     = PH_WIN;
        end
      end
      PH_WIN: begin
        if (win_tmr_q >= cfg_i.window_ms) begin
          phase_d = PH_IDLE;
        end else if (!level_i) begin
          phase_tmr_d = '0;
          phase_d     = PH_DEB2;
        end else begin
          win_tmr_d = win_tmr_inc;
        end
      end
      PH_DEB2: begin
        win_tmr_d   = win_tmr_inc;
        phase_tmr_d = phase_tmr_inc;
        if (deb_done) begin
          phase_d = level_i ? PH_WIN : PH_HELD2;
        end
      end
      PH_HELD2: begin
        if (level_i) begin
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Result fields of this tick
  always_comb begin
    ev   = EV_NONE;
    dur  = '0;
    held = '0;
    case (phase_q)
      PH_DEB1: begin
        if (deb_done && !level_i) begin
          ev = EV_DOWN;
        end
      end
      PH_HELD: begin
        if (release_now) begin
          ev  = EV_UP;
          dur = press_tmr_inc;
        end else begin
          held = press_tmr_inc;
        end
      end
      PH_HELD2: begin
        if (level_i) begin
          ev = EV_DOUBLE;
        end
      end
      default: begin
        ev = EV_NONE;
      end
    endcase
  end

  // Drop events while disabled
  always_comb begin
    res_o.event_res    = cfg_i.events_enable ? ev : EV_NONE;
    res_o.press_len_ms = cfg_i.events_enable ? dur : '0;
    res_o.held_ms      = held;
    res_o.pressed      = !level_i;
  end

  // Advance the state once per tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      phase_tmr_q  <= '0;
      press_tmr_q  <= '0;
      win_tmr_q    <= '0;
      prev_level_q <= 1'b1;
    end else if (step_i) begin
      phase_q      <= phase_d;
      phase_tmr_q  <= phase_tmr_d;
      press_tmr_q  <= press_tmr_d;
      win_tmr_q    <= win_tmr_d;
      prev_level_q <= level_i;
    end
  end

endmodule

// File: src/button_click_event_detector.sv
// Button click event detector.
// Input stream: one transfer per millisecond tick; s_axis_tdata[0] is the
// sampled button level, 0 meaning pressed. Output stream: exactly one result
// transfer per input tick, carrying the event code (none, press down, press
// up, double click), the press duration on press up, the live press time and
// the raw pressed state.
// Configuration: write cfg_we_i with cfg_idx_i 0 events enable, 1 debounce
// ticks, 2 double-click window ticks, 3 hold limit ticks. Write only while
// no tick is in flight.
// Each tick is held in the input register and its result in the result register,
// from which it can transfer out; a receiver stall can hold a tick in the input
// register in between. The block takes one tick per cycle while the receiver
// does not stall, set by the single registered pass through the phase machine.
// Reset clears the valid flags of both registers, returns the machine to idle
// with the button seen as released, and loads the default settings (events off,
// 50, 300, 60000). When the receiver stalls the result register holds, the input
// register still takes one more tick if it is empty, then s_axis_tready drops.
module button_click_event_detector import bced_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [0] level, [7:1] zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [1:0] event_res, [21:2] press_len_ms,
                                               // [41:22] held_ms, [42] pressed, [47:43] zero
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  cfg_t    cfg_q;
  logic    in_v_q;
  logic    level_q;
  logic    out_v_q;
  result_t out_q;
  result_t res;
  logic    out_load;
  logic    step;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.events_enable <= RstEventsEnable;
      cfg_q.debounce_ms   <= RstDebounce;
      cfg_q.window_ms     <= RstWindow;
      cfg_q.hold_limit_ms <= RstHoldLimit;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegEventsEnable: cfg_q.events_enable <= cfg_data_i[0];
        RegDebounce:     cfg_q.debounce_ms   <= cfg_data_i[DebW-1:0];
        RegWindow:       cfg_q.window_ms     <= cfg_data_i[WinW-1:0];
        RegHoldLimit:    cfg_q.hold_limit_ms <= cfg_data_i[DurW-1:0];
        default:         cfg_q.events_enable <= cfg_q.events_enable;
      endcase
    end
  end

  // Handshake: the result register frees up when empty or being taken
  assign out_load      = !out_v_q || m_axis_tready;
  assign step          = in_v_q && out_load;
  assign s_axis_tready = !in_v_q || out_load;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      level_q <= s_axis_tdata[0];
    end
  end

  bced_fsm u_fsm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .level_i (level_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutTdataW - $bits(result_t)){1'b0}}, out_q};

endmodule

// File: src/bced_checker.sv
module bced_checker import bced_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata
);

  logic [1:0]      ev;
  logic [DurW-1:0] dur;
  logic [DurW-1:0] held;
  logic            pressed;

  assign ev      = m_axis_tdata[1:0];
  assign dur     = m_axis_tdata[21:2];
  assign held    = m_axis_tdata[41:22];
  assign pressed = m_axis_tdata[42];

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Duration is only reported with a press up
  a_dur_only_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ev != EV_UP |-> dur == '0)
    else $error("duration outside press up");

  // A press up always carries a non-zero duration and no live time
  a_up_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ev == EV_UP |-> dur != '0 && held == '0)
    else $error("press up fields wrong");

  // Live press time only while the button is down and nothing is reported
  a_held_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && held != '0 |-> pressed && ev == EV_NONE)
    else $error("live press time while released or with an event");

  // Double click is reported on release
  a_double_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ev == EV_DOUBLE |-> !pressed)
    else $error("double click while pressed");

endmodule

bind button_click_event_detector bced_checker u_bced_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bced_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int MaxPrinted = 100;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;     // [0] level, [7:1] zero
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;          // [1:0] event_res, [21:2] press_len_ms,
                                               // [41:22] held_ms, [42] pressed, [47:43] zero
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgW-1:0]      cfg_data_i = '0;

  button_click_event_detector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Tick levels waiting to be sent, and results owed by the block
  logic    tick_backlog[$];
  result_t due_results[$];

  // Idling bounds for the current phase
  int src_max_gap = 0;
  int snk_max_stall = 0;

  int mismatch_cnt = 0;
  int results_seen = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;

  // Mirror of the detector state and settings
  phase_e          ph_st = PH_IDLE;
  logic [WinW-1:0] deb_tmr = '0;
  logic [DurW-1:0] press_tmr = '0;
  logic [WinW-1:0] win_tmr = '0;
  logic            prev_lvl = 1'b1;
  cfg_t            cfg_mirror = '{RstEventsEnable, RstDebounce, RstWindow, RstHoldLimit};

  // Advance the mirrored detector by one tick and return the result it owes
  function automatic result_t next_click_result(logic lvl);
    result_t r;
    r.event_res    = EV_NONE;
    r.press_len_ms = '0;
    r.held_ms      = '0;
    r.pressed      = ~lvl;
    case (ph_st)
      PH_IDLE: begin
        if (prev_lvl && !lvl) begin
          ph_st   = PH_DEB1;
          deb_tmr = '0;
        end
      end
      PH_DEB1: begin
        if (deb_tmr != WinMax) deb_tmr++;
        if (deb_tmr >= cfg_mirror.debounce_ms) begin
          if (!lvl) begin
            r.event_res = EV_DOWN;
            press_tmr   = '0;
            ph_st       = PH_HELD;
          end else begin
            ph_st = PH_IDLE;
          end
        end
      end
      PH_HELD: begin
        if (press_tmr != DurMax) press_tmr++;
        if (lvl || press_tmr > cfg_mirror.hold_limit_ms || press_tmr == DurMax) begin
          r.event_res    = EV_UP;
          r.press_len_ms = press_tmr;
          press_tmr      = '0;
          win_tmr        = '0;
          ph_st          = PH_WIN;
        end else begin
          r.held_ms = press_tmr;
        end
      end
      PH_WIN: begin
        if (win_tmr >= cfg_mirror.window_ms) begin
          ph_st = PH_IDLE;
        end else if (!lvl) begin
          deb_tmr = '0;
          ph_st   = PH_DEB2;
        end else if (win_tmr != WinMax) begin
          win_tmr++;
        end
      end
      PH_DEB2: begin
        if (win_tmr != WinMax) win_tmr++;
        if (deb_tmr != WinMax) deb_tmr++;
        if (deb_tmr >= cfg_mirror.debounce_ms) ph_st = lvl ? PH_WIN : PH_HELD2;
      end
      PH_HELD2: begin
        if (lvl) begin
          r.event_res = EV_DOUBLE;
          ph_st       = PH_IDLE;
        end
      end
      default: ph_st = PH_IDLE;
    endcase
    prev_lvl = lvl;
    if (!cfg_mirror.events_enable) begin
      r.event_res    = EV_NONE;
      r.press_len_ms = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted)
      $display("mismatch on result %0d: %s got %0d, want %0d", results_seen, what, got, want);
  endtask

  task automatic check_result(logic [OutTdataW-1:0] data);
    result_t got;
    result_t want;
    got = result_t'(data[$bits(result_t)-1:0]);
    if (data[OutTdataW-1:$bits(result_t)] !== '0)
      report_mismatch("padding", data[OutTdataW-1:$bits(result_t)], 0);
    if (due_results.size() == 0) begin
      report_mismatch("unexpected result, event_res", got.event_res, -1);
    end else begin
      want = due_results.pop_front();
      if (got.event_res !== want.event_res)
        report_mismatch("event_res", got.event_res, want.event_res);
      if (got.press_len_ms !== want.press_len_ms)
        report_mismatch("press_len_ms", got.press_len_ms, want.press_len_ms);
      if (got.held_ms !== want.held_ms)
        report_mismatch("held_ms", got.held_ms, want.held_ms);
      if (got.pressed !== want.pressed)
        report_mismatch("pressed", got.pressed, want.pressed);
    end
    results_seen++;
  endtask

  // Driver: present queued ticks, predict on each transfer, pause between ticks
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        due_results.push_back(next_click_result(s_axis_tdata[0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          s_axis_tvalid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (tick_backlog.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= InTdataW'(tick_backlog.pop_front());
          gap_left      <= $urandom_range(0, src_max_gap);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then stall for a drawn number of cycles
  always @(posedge clk_i) begin
    int stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_result(m_axis_tdata);
      stall = $urandom_range(0, snk_max_stall);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall - 1;
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic write_setting(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegEventsEnable: cfg_mirror.events_enable = val[0];
      RegDebounce:     cfg_mirror.debounce_ms   = val[DebW-1:0];
      RegWindow:       cfg_mirror.window_ms     = val[WinW-1:0];
      default:         cfg_mirror.hold_limit_ms = val[DurW-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_settings(int en, int deb, int win, int hold);
    write_setting(RegEventsEnable, CfgW'(en));
    write_setting(RegDebounce, CfgW'(deb));
    write_setting(RegWindow, CfgW'(win));
    write_setting(RegHoldLimit, CfgW'(hold));
  endtask

  // Hold the sender back until every owed result has been transferred
  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic queue_run(logic lvl, int n);
    repeat (n) tick_backlog.push_back(lvl);
  endtask

  task automatic queue_bits(string s);
    for (int i = 0; i < s.len(); i++) tick_backlog.push_back(s[i] != "0");
  endtask

  // One press, a press with a second press after it, or contact bounce
  task automatic queue_gesture();
    int kind;
    int deb;
    int win;
    int hold;
    kind = $urandom_range(0, 9);
    deb  = cfg_mirror.debounce_ms;
    win  = cfg_mirror.window_ms;
    hold = cfg_mirror.hold_limit_ms;
    queue_run(1'b1, $urandom_range(1, 3));
    if (kind < 8) begin
      queue_run(1'b0, $urandom_range(1, deb + hold + 3));
      queue_run(1'b1, $urandom_range(1, win + 3));
      if (kind >= 3) begin
        queue_run(1'b0, $urandom_range(1, deb + 6));
        queue_run(1'b1, $urandom_range(1, win + 3));
      end
    end else begin
      repeat ($urandom_range(1, 8)) tick_backlog.push_back(1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, events off: start a debounce and leave it running
    src_max_gap   = 6;
    snk_max_stall = 6;
    queue_bits("10");
    wait_drained();

    // Short settings: abort, press, forced release, double click,
    // plain press with window expiry, bounce, failed second debounce
    apply_settings(1, 0, 2, 1);
    queue_bits("110000001");
    queue_bits("1001111");
    queue_bits("011");
    queue_bits("00101111");
    wait_drained();

    // Longer settings with no idling: long debounce, long window, no forced release
    src_max_gap   = 0;
    snk_max_stall = 0;
    apply_settings(1, 20, 30, DurMax);
    queue_run(1'b1, 2);
    queue_run(1'b0, 25);
    queue_run(1'b1, 3);
    queue_run(1'b0, 25);
    queue_run(1'b1, 2);
    queue_run(1'b0, 25);
    queue_run(1'b1, 45);
    queue_run(1'b0, 10);
    queue_run(1'b1, 12);
    wait_drained();

    // Random gestures under a series of settings
    for (int p = 0; p < 10; p++) begin
      if (p == 0) apply_settings(1, 0, 0, 1);
      else if (p == 1) apply_settings(0, 0, 0, 1);
      else if (p == 2) apply_settings(0, 6, 20, 25);
      else
        apply_settings($urandom_range(0, 5) != 0, $urandom_range(0, 5),
                       $urandom_range(0, 24), $urandom_range(1, 30));
      src_max_gap   = (p % 3 == 1) ? 0 : 6;
      snk_max_stall = (p % 4 == 2) ? 0 : 6;
      while (tick_backlog.size() < 20) queue_gesture();
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bced_pkg.sv
src/bced_fsm.sv
src/button_click_event_detector.sv
src/bced_checker.sv
tb/sv/testbench.sv
